FILE: src/led_blink_breathe_controller_top_defines.svh
// ----------------------------------------------------------------------------
// LED blink/breathe controller assertion macros
// Shared concurrent check wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_BREATHE_CONTROLLER_TOP_DEFINES_SVH
`define LED_BLINK_BREATHE_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define LBBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// LED blink/breathe controller package
// Command codes, activity codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbbc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ON      = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_BREATHE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_BLINK   = 2'd1,
    ACT_BREATHE = 2'd2
  } activity_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_PERIOD  = 2'd1;

  localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd500;
  localparam logic [15:0] RAMP_STEP_PERIOD_RST  = 16'd10;

  typedef struct packed {
    logic [7:0] led_level;
    activity_t  activity;
    logic       sequence_done;
  } lbbc_result_t;

endpackage

`default_nettype wire

FILE: src/lbbc_core.sv
// ----------------------------------------------------------------------------
// LED blink/breathe controller core
// Sequence state and its one-item update: tick counting, blink toggles,
// breathing ramp and cycle counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbbc_core
  import lbbc_pkg::*;
#(
  parameter int unsigned LEVEL_MAX = 255
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step_en,
  input  wire logic [1:0]   mode,
  input  wire logic [15:0]  repeat_count,
  input  wire logic [15:0]  blink_half_period,
  input  wire logic [15:0]  ramp_step_period,
  output lbbc_result_t      res
);

  localparam int unsigned LW = $clog2(LEVEL_MAX + 1);
  localparam logic [LW-1:0] LVL_MAX = LW'(LEVEL_MAX);

  activity_t     act_r, act_nxt;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic [16:0]   toggle_r, toggle_nxt;
  logic [15:0]   target_r, target_nxt;
  logic [LW-1:0] ramp_r, ramp_nxt;
  logic          rising_r, rising_nxt;
  logic [15:0]   cycles_r, cycles_nxt;
  logic [LW-1:0] drive_r, drive_nxt;

  logic [15:0]   period;
  logic [15:0]   period_eff;
  logic [15:0]   elapsed_inc;
  logic          hit;
  logic [16:0]   toggle_inc;
  logic [LW-1:0] ramp_step;
  logic [15:0]   cycles_inc;
  logic          go_idle;
  logic          done;

  // Shared period counter for whichever sequence runs
  always_comb begin
    period      = (act_r == ACT_BLINK) ? blink_half_period : ramp_step_period;
    period_eff  = (period == 16'd0) ? 16'd1 : period;
    elapsed_inc = elapsed_r + 16'd1;
    hit         = (elapsed_inc >= period_eff);
    toggle_inc  = toggle_r + 17'd1;
    if (rising_r) begin
      ramp_step = ramp_r + LW'(1);
    end else begin
      ramp_step = (ramp_r == '0) ? '0 : ramp_r - LW'(1);
    end
    cycles_inc = (cycles_r == 16'hFFFF) ? cycles_r : cycles_r + 16'd1;
  end

  always_comb begin
    act_nxt     = act_r;
    elapsed_nxt = elapsed_r;
    toggle_nxt  = toggle_r;
    target_nxt  = target_r;
    ramp_nxt    = ramp_r;
    rising_nxt  = rising_r;
    cycles_nxt  = cycles_r;
    drive_nxt   = drive_r;
    go_idle     = 1'b0;
    done        = 1'b0;

    unique case (mode_t'(mode))
      MODE_ON: begin
        go_idle = 1'b1;
      end
      MODE_BLINK, MODE_BREATHE: begin
        go_idle = 1'b1;
      end
      MODE_TICK: begin
        unique case (act_r)
          ACT_BLINK: begin
            if (hit) begin
              elapsed_nxt = '0;
              drive_nxt   = (drive_r == '0) ? LVL_MAX : '0;
              toggle_nxt  = toggle_inc;
              if (toggle_inc >= {target_r, 1'b0}) begin
                go_idle = 1'b1;
                done    = 1'b1;
              end
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
          ACT_BREATHE: begin
            if (hit) begin
              elapsed_nxt = '0;
              ramp_nxt    = ramp_step;
              drive_nxt   = ramp_step;
              if (ramp_step == '0 || ramp_step >= LVL_MAX) begin
                rising_nxt = !rising_r;
                // Turning back to rising at zero closes one breath
                if (!rising_r) begin
                  cycles_nxt = cycles_inc;
                  if (cycles_inc >= target_r) begin
                    go_idle = 1'b1;
                    done    = 1'b1;
                  end
                end
              end
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (go_idle) begin
      act_nxt     = ACT_IDLE;
      elapsed_nxt = '0;
      toggle_nxt  = '0;
      target_nxt  = '0;
      ramp_nxt    = '0;
      rising_nxt  = 1'b1;
      cycles_nxt  = '0;
      drive_nxt   = '0;
      if (mode_t'(mode) == MODE_ON) begin
        drive_nxt = LVL_MAX;
      end else if (mode_t'(mode) == MODE_BLINK) begin
        act_nxt    = ACT_BLINK;
        target_nxt = repeat_count;
      end else if (mode_t'(mode) == MODE_BREATHE) begin
        act_nxt    = ACT_BREATHE;
        target_nxt = repeat_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= ACT_IDLE;
      elapsed_r <= '0;
      toggle_r  <= '0;
      target_r  <= '0;
      ramp_r    <= '0;
      rising_r  <= 1'b1;
      cycles_r  <= '0;
      drive_r   <= '0;
    end else if (step_en) begin
      act_r     <= act_nxt;
      elapsed_r <= elapsed_nxt;
      toggle_r  <= toggle_nxt;
      target_r  <= target_nxt;
      ramp_r    <= ramp_nxt;
      rising_r  <= rising_nxt;
      cycles_r  <= cycles_nxt;
      drive_r   <= drive_nxt;
    end
  end

  always_comb begin
    res.led_level     = 8'(drive_nxt);
    res.activity      = act_nxt;
    res.sequence_done = done;
  end

endmodule

`default_nettype wire

FILE: src/led_blink_breathe_controller_top.sv
// ----------------------------------------------------------------------------
// LED blink/breathe controller top level
// Accepts tick and command items, drives LED duty, activity and done flags.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick (mode 0) or a command: steady on
// (1), blink repeat_count times (2), breathe repeat_count times (3). A
// blink or breathe command restarts the controller with the LED off, and
// steady on restarts it with the LED at full level; the first toggle or
// ramp step comes one full period after the command. Exactly one result
// item follows each input item, in order. The block takes one item per
// clock while the output side is not stalled: an item sits in the input
// register while the state update runs on it, and its result is loaded
// into the output register, raising out_valid. The output register
// decouples the channels, so a new item can be taken into an empty input
// register while a finished result still waits. Period registers are
// written through the cfg port (index 0 blink half period, index 1 ramp
// step period, other indexes ignored) and must only change while the block
// is idle; a period of zero acts as one. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "led_blink_breathe_controller_top_defines.svh"

module led_blink_breathe_controller_top
  import lbbc_pkg::*;
#(
  parameter int unsigned LEVEL_MAX = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_mode,
  input  wire logic [15:0]          in_repeat_count,
  // result item channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_led_level,
  output logic [1:0]                out_activity,
  output logic                      out_sequence_done,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic         s1_valid_r;
  logic [1:0]   s1_mode_r;
  logic [15:0]  s1_count_r;
  logic         out_valid_r;
  lbbc_result_t out_res_r;
  lbbc_result_t core_res;
  logic [15:0]  blink_half_r;
  logic [15:0]  ramp_step_r;
  logic         advance;

  // Move the held item into the core when the output register can take it
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r <= BLINK_HALF_PERIOD_RST;
      ramp_step_r  <= RAMP_STEP_PERIOD_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BLINK_HALF_PERIOD) begin
        blink_half_r <= cfg_data;
      end else if (cfg_index == REG_RAMP_STEP_PERIOD) begin
        ramp_step_r <= cfg_data;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= in_mode;
      s1_count_r <= in_repeat_count;
    end
  end

  lbbc_core #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_en           (advance),
    .mode              (s1_mode_r),
    .repeat_count      (s1_count_r),
    .blink_half_period (blink_half_r),
    .ramp_step_period  (ramp_step_r),
    .res               (core_res)
  );

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_level     = out_res_r.led_level;
  assign out_activity      = out_res_r.activity;
  assign out_sequence_done = out_res_r.sequence_done;

  `LBBC_ASSERT_NOW(a_done_is_idle, clk, rst_n,
    out_valid_r && out_res_r.sequence_done,
    out_res_r.activity == ACT_IDLE && out_res_r.led_level == 8'd0,
    "finished sequence must leave the LED off and idle")
  `LBBC_ASSERT_NEXT(a_held_item_kept, clk, rst_n,
    s1_valid_r && !advance, s1_valid_r,
    "stalled item dropped from input register")
  `LBBC_ASSERT_NOW(a_no_overwrite, clk, rst_n,
    out_valid_r && !out_ready, !advance,
    "result register overwritten before it was taken")
  `LBBC_ASSERT_NEXT(a_cfg_blink_write, clk, rst_n,
    cfg_valid && cfg_index == REG_BLINK_HALF_PERIOD, blink_half_r == $past(cfg_data),
    "blink half period write lost")

endmodule

`default_nettype wire
